>>> rtl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the alphabet mapping of the Base64 stream
// encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  // Number of bits held between bytes
  typedef enum logic [1:0] {
    PH_NONE = 2'd0,
    PH_TWO  = 2'd1,
    PH_FOUR = 2'd2
  } phase_e;

  // Most characters one byte can produce
  localparam int unsigned MaxSyms = 4;
  localparam int unsigned SymIdxW = $clog2(MaxSyms);

  localparam logic [7:0] PadChar = 8'd61;  // '='

  // One output symbol: a sextet or a pad character
  typedef struct packed {
    logic       pad;
    logic [5:0] six;
  } sym_t;

  // Work for the back end: the symbols one byte produced
  typedef struct packed {
    sym_t [MaxSyms-1:0] syms;
    logic [SymIdxW-1:0] last_idx;  // index of the final symbol
    logic               last;      // message ends with this group
  } group_t;

  // Sextet to ASCII, standard alphabet
  function automatic logic [7:0] sextet_to_ascii(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'd71 + {2'b00, v};         // 'a' - 26
    end else if (v < 6'd62) begin
      c = {2'b00, v} - 8'd4;          // '0' - 52
    end else if (v == 6'd62) begin
      c = 8'd43;                      // '+'
    end else begin
      c = 8'd47;                      // '/'
    end
    return c;
  endfunction

endpackage

>>> rtl/base64_stream_encoder_core.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_core
// Base64 stream encoder, standard alphabet, with '=' padding at message end.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): one raw byte per transfer, with
//   last_byte_i set on the final byte of a message.
//   Output channel (out_valid_o / out_stall_i): one ASCII character per
//   transfer; last_char_o marks the final character of a message.
//   A byte yields one or two characters mid-message and two to four on the
//   final byte. The back end emits one character per cycle while the
//   receiver does not stall; the sustained rate is set by that single
//   output register.
//   The first character of a byte passes the queue write at its transfer
//   and then the output register load.
//   The queue holds QueueDepth byte groups; when it is full in_stall_o rises.
//   When the receiver stalls, the output character holds, the queue fills
//   and the input then stalls; nothing is dropped.
//   Reset clears the held bits, the queue and the output valid; the first
//   byte after reset starts a new message.
// ----------------------------------------------------------------------------
module base64_stream_encoder_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       last_char_o
);

  b64e_pkg::group_t push_group, head_group;
  logic             q_push, q_pop, q_full, q_empty;

  // Byte intake and splitting
  b64e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_group_o   (push_group)
  );

  // Group queue
  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_group_i (push_group),
    .pop_i        (q_pop),
    .head_o       (head_group),
    .full_o       (q_full),
    .empty_o      (q_empty)
  );

  // Character output
  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_group),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

endmodule

>>> rtl/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Accepts raw bytes, joins them with held bits and splits them into sextets
// and pad symbols for the back end.
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output b64e_pkg::group_t  q_group_o
);

  b64e_pkg::phase_e phase_q, phase_d;
  logic [3:0]       residue_q, residue_d;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Split the byte against the held bits
  always_comb begin
    q_group_o          = '0;
    q_group_o.last     = last_byte_i;
    phase_d            = phase_q;
    residue_d          = residue_q;
    case (phase_q)
      b64e_pkg::PH_TWO: begin
        q_group_o.syms[0].six = {residue_q[1:0], data_byte_i[7:4]};
        phase_d   = b64e_pkg::PH_FOUR;
        residue_d = data_byte_i[3:0];
        if (last_byte_i) begin
          q_group_o.syms[1].six = {data_byte_i[3:0], 2'b00};
          q_group_o.syms[2].pad = 1'b1;
          q_group_o.last_idx    = 2'd2;
        end
      end
      b64e_pkg::PH_FOUR: begin
        q_group_o.syms[0].six = {residue_q, data_byte_i[7:6]};
        q_group_o.syms[1].six = data_byte_i[5:0];
        q_group_o.last_idx    = 2'd1;
        phase_d   = b64e_pkg::PH_NONE;
        residue_d = 4'd0;
      end
      default: begin
        // no bits held (unused code too)
        q_group_o.syms[0].six = data_byte_i[7:2];
        phase_d   = b64e_pkg::PH_TWO;
        residue_d = {2'b00, data_byte_i[1:0]};
        if (last_byte_i) begin
          q_group_o.syms[1].six = {data_byte_i[1:0], 4'b0000};
          q_group_o.syms[2].pad = 1'b1;
          q_group_o.syms[3].pad = 1'b1;
          q_group_o.last_idx    = 2'd3;
        end
      end
    endcase
    // message end clears the state
    if (last_byte_i) begin
      phase_d   = b64e_pkg::PH_NONE;
      residue_d = 4'd0;
    end
  end

  // State update on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= b64e_pkg::PH_NONE;
      residue_q <= 4'd0;
    end else if (q_push_o) begin
      phase_q   <= phase_d;
      residue_q <= residue_d;
    end
  end

endmodule

>>> rtl/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Small FIFO of symbol groups between the front and back ends.
// ----------------------------------------------------------------------------
module b64e_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  b64e_pkg::group_t  push_group_i,
  input  logic              pop_i,
  output b64e_pkg::group_t  head_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  b64e_pkg::group_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_group_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Walks the symbols of the queued group, maps each to ASCII and holds it in
// the output register.
// ----------------------------------------------------------------------------
module b64e_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  b64e_pkg::group_t  head_i,
  input  logic              q_empty_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_char_o,
  output logic              last_char_o
);

  logic [b64e_pkg::SymIdxW-1:0] idx_q;
  logic                         valid_q;
  logic [7:0]                   char_q;
  logic                         last_q;
  logic                         load;
  logic                         at_end;
  b64e_pkg::sym_t               sym;

  assign load    = !q_empty_i && (!valid_q || !out_stall_i);
  assign sym     = head_i.syms[idx_q];
  assign at_end  = (idx_q == head_i.last_idx);
  assign q_pop_o = load && at_end;

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign last_char_o = last_q;

  // Symbol index and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q   <= at_end ? '0 : idx_q + 1'b1;
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= sym.pad ? b64e_pkg::PadChar : b64e_pkg::sextet_to_ascii(sym.six);
      last_q <= head_i.last && at_end;
    end
  end

endmodule
